@@ rtl/smc_pkg.sv @@
package smc_pkg;

  // Elapsed-time counter width; the counter saturates at its all-ones value.
  localparam int ELAPSED_W = 22;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  localparam int TIMEOUT_W     = 12;
  localparam int TIMEOUT_RESET = 60;
  localparam int MS_PER_SECOND = 1000;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = TIMEOUT_W;

  localparam logic [CFG_IDX_W-1:0] REG_USE_SWITCHES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_OPEN  = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_ABORT = 3'd3,
    KIND_INIT  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OPEN    = 3'd0,
    ST_CLOSED  = 3'd1,
    ST_OPENING = 3'd2,
    ST_CLOSING = 3'd3,
    ST_ERROR   = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       sw_open;
    logic       sw_closed;
  } item_t;

  typedef struct packed {
    logic                 use_switches;
    logic [ELAPSED_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    status_t status;
    logic    slewing;
    logic    relay_open;
    logic    relay_close;
    logic    accepted;
  } result_t;

endpackage

@@ rtl/smc_cfg.sv @@
module smc_cfg #(
  parameter int MS_PER_SECOND = smc_pkg::MS_PER_SECOND
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [smc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [smc_pkg::CFG_DATA_W-1:0] wr_data,
  output smc_pkg::cfg_t                  cfg
);

  localparam int MS_W  = $clog2(MS_PER_SECOND + 1);
  localparam int RAW_W = smc_pkg::TIMEOUT_W + MS_W;
  localparam int PROD_W = (RAW_W > smc_pkg::ELAPSED_W) ? RAW_W : smc_pkg::ELAPSED_W + 1;
  localparam longint RESET_PROD = longint'(smc_pkg::TIMEOUT_RESET) * MS_PER_SECOND;
  localparam logic [smc_pkg::ELAPSED_W-1:0] LIMIT_RESET =
    (RESET_PROD > longint'(smc_pkg::ELAPSED_MAX)) ? smc_pkg::ELAPSED_MAX
                                                  : smc_pkg::ELAPSED_W'(RESET_PROD);

  logic [PROD_W-1:0]             prod;
  logic [smc_pkg::ELAPSED_W-1:0] limit_next;

  // The limit in milliseconds is formed once, when the timeout is written.
  // Clamping to the counter maximum keeps "never times out" for large limits.
  assign prod = PROD_W'(wr_data) * PROD_W'(MS_PER_SECOND);
  assign limit_next = (prod > PROD_W'(smc_pkg::ELAPSED_MAX)) ? smc_pkg::ELAPSED_MAX
                                                            : prod[smc_pkg::ELAPSED_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_switches <= 1'b0;
      cfg.limit        <= LIMIT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        smc_pkg::REG_USE_SWITCHES: cfg.use_switches <= wr_data[0];
        smc_pkg::REG_TIMEOUT:      cfg.limit        <= limit_next;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/smc_core.sv @@
module smc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  smc_pkg::item_t   item,
  input  smc_pkg::cfg_t    cfg,
  output smc_pkg::result_t result
);

  smc_pkg::status_t              status, status_next;
  logic                          slew, slew_next;
  logic                          open_relay, open_relay_next;
  logic                          close_relay, close_relay_next;
  logic [smc_pkg::ELAPSED_W-1:0] elapsed, elapsed_next;
  logic [smc_pkg::ELAPSED_W-1:0] elapsed_inc;
  logic                          moving;
  logic                          timed_out;
  logic                          accepted;

  assign moving      = (status == smc_pkg::ST_OPENING) || (status == smc_pkg::ST_CLOSING);
  assign elapsed_inc = (elapsed == smc_pkg::ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
  assign timed_out   = elapsed_inc > cfg.limit;

  always_comb begin
    status_next      = status;
    slew_next        = slew;
    open_relay_next  = open_relay;
    close_relay_next = close_relay;
    elapsed_next     = elapsed;
    accepted         = 1'b1;
    case (smc_pkg::kind_t'(item.kind))
      smc_pkg::KIND_TICK: begin
        if (moving) begin
          elapsed_next = elapsed_inc;
          if (timed_out || (cfg.use_switches &&
              ((status == smc_pkg::ST_OPENING && item.sw_open) ||
               (status == smc_pkg::ST_CLOSING && item.sw_closed)))) begin
            slew_next        = 1'b0;
            open_relay_next  = 1'b0;
            close_relay_next = 1'b0;
            // In switch mode a timeout wins over a switch in the same tick.
            if (cfg.use_switches && timed_out) begin
              status_next  = smc_pkg::ST_ERROR;
              elapsed_next = '0;
            end else if (status == smc_pkg::ST_OPENING) begin
              status_next = smc_pkg::ST_OPEN;
            end else begin
              status_next = smc_pkg::ST_CLOSED;
            end
          end
        end
      end
      smc_pkg::KIND_OPEN: begin
        if (status == smc_pkg::ST_CLOSING) begin
          accepted = 1'b0;
        end else if (status != smc_pkg::ST_OPENING) begin
          status_next      = smc_pkg::ST_OPENING;
          slew_next        = 1'b1;
          open_relay_next  = 1'b1;
          close_relay_next = 1'b0;
          elapsed_next     = '0;
        end
      end
      smc_pkg::KIND_CLOSE: begin
        if (status == smc_pkg::ST_OPENING) begin
          accepted = 1'b0;
        end else if (status != smc_pkg::ST_CLOSING) begin
          status_next      = smc_pkg::ST_CLOSING;
          slew_next        = 1'b1;
          open_relay_next  = 1'b0;
          close_relay_next = 1'b1;
          elapsed_next     = '0;
        end
      end
      smc_pkg::KIND_ABORT: begin
        status_next      = smc_pkg::ST_ERROR;
        slew_next        = 1'b0;
        open_relay_next  = 1'b0;
        close_relay_next = 1'b0;
        elapsed_next     = '0;
      end
      smc_pkg::KIND_INIT: begin
        if (cfg.use_switches && item.sw_closed) begin
          status_next = smc_pkg::ST_CLOSED;
        end else if (cfg.use_switches && item.sw_open) begin
          status_next = smc_pkg::ST_OPEN;
        end else begin
          status_next = smc_pkg::ST_ERROR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status      <= smc_pkg::ST_ERROR;
      slew        <= 1'b0;
      open_relay  <= 1'b0;
      close_relay <= 1'b0;
      elapsed     <= '0;
    end else if (step) begin
      status      <= status_next;
      slew        <= slew_next;
      open_relay  <= open_relay_next;
      close_relay <= close_relay_next;
      elapsed     <= elapsed_next;
    end
  end

  assign result.status      = status_next;
  assign result.slewing     = slew_next;
  assign result.relay_open  = open_relay_next;
  assign result.relay_close = close_relay_next;
  assign result.accepted    = accepted;

  a_relays_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(open_relay && close_relay))
    else $error("both relays driven");

  a_slew_matches_relays: assert property (@(posedge clk) disable iff (rst)
    slew == (open_relay || close_relay))
    else $error("slew flag disagrees with relays");

  // Initialise may change the status while the relays stay on, so only the
  // moving states pin down the relay drive.
  a_moving_relay: assert property (@(posedge clk) disable iff (rst)
    (status != smc_pkg::ST_OPENING || open_relay) &&
    (status != smc_pkg::ST_CLOSING || close_relay))
    else $error("relay drive disagrees with status");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    (step && !accepted) |=> $stable(status) && $stable(elapsed))
    else $error("refused command changed state");

endmodule

@@ rtl/shutter_motion_controller.sv @@
// Shutter motion controller. Each word on the input stream is one event: a
// one-millisecond tick, an open or close command, an abort, or an initialise
// step, sent with the current levels of the two limit switches. Every input
// word produces exactly one output word that shows the shutter status, the
// slewing flag and both relay drives after the event, plus a flag that is low
// when a command was refused because the opposite motion was running. The
// block takes one word per clock cycle when the output side keeps up; a word
// passes an input register and then the result register on its way to the
// output. The millisecond limit is formed from the timeout register when it
// is written, so the per-word update is one increment and one compare.
// Configuration writes are always taken and should be made while no words
// are in flight.
module shutter_motion_controller #(
  parameter int MS_PER_SECOND = smc_pkg::MS_PER_SECOND
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // [0] switch_opened, [1] switch_closed
  input  logic [2:0]                     s_tuser,  // [2:0] kind
  // Result stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,  // [2:0] shutter_status, [3] slewing,
                                                   // [4] relay_open_on, [5] relay_close_on,
                                                   // [6] accepted
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [smc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smc_pkg::CFG_DATA_W-1:0] cfg_data
);

  smc_pkg::cfg_t    cfg;
  smc_pkg::item_t   in_item;
  smc_pkg::result_t core_result;
  smc_pkg::result_t out_result;
  logic             in_valid;
  logic             out_advance;
  logic             step;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  smc_cfg #(
    .MS_PER_SECOND(MS_PER_SECOND)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_index(cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // Two-stage pipeline: the output register moves whenever it is empty or
  // being drained, and the input register refills behind it in the same cycle.
  assign out_advance = !m_tvalid || m_tready;
  assign s_tready    = !in_valid || out_advance;
  assign step        = in_valid && out_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind      <= s_tuser;
      in_item.sw_open   <= s_tdata[0];
      in_item.sw_closed <= s_tdata[1];
    end
  end

  smc_core u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (in_item),
    .cfg   (cfg),
    .result(core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= core_result;
    end
  end

  assign m_tdata = {1'b0, out_result.accepted, out_result.relay_close,
                    out_result.relay_open, out_result.slewing, 3'(out_result.status)};

endmodule

@@ sim/shutter_motion_checker.sv @@
`timescale 1ns / 1ps

// Watches the event, result and register channels of the shutter controller.
// It keeps its own copy of the controller state, works out the result word
// that each accepted event should produce, and compares every result word
// that leaves the block against the oldest one still waiting.
module shutter_motion_checker
  import smc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [7:0]             s_tdata,
  input  logic [2:0]             s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [7:0]             m_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     failures,
  output int                     outstanding,
  output int                     compared,
  output int                     timeouts,
  output int                     switch_stops
);

  typedef struct {
    status_t status;
    logic    slewing;
    logic    relay_open;
    logic    relay_close;
    logic    accepted;
  } shutter_view_t;

  shutter_view_t awaited_q[$];

  status_t              sh_status = ST_ERROR;
  logic                 sh_slew = 1'b0;
  logic                 sh_open = 1'b0;
  logic                 sh_close = 1'b0;
  logic [ELAPSED_W-1:0] sh_elapsed = '0;
  logic                 sh_use_sw = 1'b0;
  logic [TIMEOUT_W-1:0] sh_timeout = TIMEOUT_W'(TIMEOUT_RESET);

  int fail_count = 0;
  int compare_count = 0;
  int timeout_count = 0;
  int switch_count = 0;

  task automatic report(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic halt_motion(input status_t final_st);
    sh_status = final_st;
    sh_slew = 1'b0;
    sh_open = 1'b0;
    sh_close = 1'b0;
  endtask

  task automatic begin_motion(input logic to_open);
    if (to_open) sh_status = ST_OPENING;
    else sh_status = ST_CLOSING;
    sh_slew = 1'b1;
    sh_elapsed = '0;
    sh_open = to_open;
    sh_close = ~to_open;
  endtask

  // One millisecond of travel. The timeout wins over a limit switch that is
  // seen on the same tick.
  task automatic millisecond_tick(input logic so, input logic sc);
    logic [31:0] limit;
    logic        late;
    if (sh_status != ST_OPENING && sh_status != ST_CLOSING) return;
    if (sh_elapsed != ELAPSED_MAX) sh_elapsed = sh_elapsed + 1'b1;
    limit = 32'(sh_timeout) * 32'(MS_PER_SECOND);
    late = 32'(sh_elapsed) > limit;
    if (sh_use_sw) begin
      if (late) begin
        halt_motion(ST_ERROR);
        sh_elapsed = '0;
        timeout_count++;
      end else if (sh_status == ST_OPENING && so) begin
        halt_motion(ST_OPEN);
        switch_count++;
      end else if (sh_status == ST_CLOSING && sc) begin
        halt_motion(ST_CLOSED);
        switch_count++;
      end
    end else if (late) begin
      if (sh_status == ST_OPENING) halt_motion(ST_OPEN);
      else halt_motion(ST_CLOSED);
      timeout_count++;
    end
  endtask

  task automatic predict_word(input logic [2:0] k, input logic so, input logic sc,
                              output shutter_view_t want);
    logic ok;
    ok = 1'b1;
    case (k)
      KIND_TICK: millisecond_tick(so, sc);
      KIND_OPEN: begin
        if (sh_status == ST_CLOSING) ok = 1'b0;
        else if (sh_status != ST_OPENING) begin_motion(1'b1);
      end
      KIND_CLOSE: begin
        if (sh_status == ST_OPENING) ok = 1'b0;
        else if (sh_status != ST_CLOSING) begin_motion(1'b0);
      end
      KIND_ABORT: begin
        halt_motion(ST_ERROR);
        sh_elapsed = '0;
      end
      KIND_INIT: begin
        if (sh_use_sw && sc) sh_status = ST_CLOSED;
        else if (sh_use_sw && so) sh_status = ST_OPEN;
        else sh_status = ST_ERROR;
      end
      default: ;
    endcase
    want.status = sh_status;
    want.slewing = sh_slew;
    want.relay_open = sh_open;
    want.relay_close = sh_close;
    want.accepted = ok;
  endtask

  task automatic check_result(input logic [7:0] w);
    shutter_view_t want;
    if (awaited_q.size() == 0) begin
      report($sformatf("result word 0x%02h arrived with nothing expected", w));
      return;
    end
    want = awaited_q.pop_front();
    compare_count++;
    if (w[2:0] != want.status)
      report($sformatf("word %0d shutter_status got %0d, expected %0d (%s)",
                       compare_count, w[2:0], want.status, want.status.name()));
    if (w[3] != want.slewing)
      report($sformatf("word %0d slewing got %0b, expected %0b",
                       compare_count, w[3], want.slewing));
    if (w[4] != want.relay_open)
      report($sformatf("word %0d relay_open_on got %0b, expected %0b",
                       compare_count, w[4], want.relay_open));
    if (w[5] != want.relay_close)
      report($sformatf("word %0d relay_close_on got %0b, expected %0b",
                       compare_count, w[5], want.relay_close));
    if (w[6] != want.accepted)
      report($sformatf("word %0d accepted got %0b, expected %0b",
                       compare_count, w[6], want.accepted));
  endtask

  always @(posedge clk) begin
    shutter_view_t next_want;
    if (rst) begin
      awaited_q.delete();
      sh_status = ST_ERROR;
      sh_slew = 1'b0;
      sh_open = 1'b0;
      sh_close = 1'b0;
      sh_elapsed = '0;
      sh_use_sw = 1'b0;
      sh_timeout = TIMEOUT_W'(TIMEOUT_RESET);
    end else begin
      // Results first: a result word can never belong to an event taken at
      // the same edge.
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_USE_SWITCHES) sh_use_sw = cfg_data[0];
        else if (cfg_index == REG_TIMEOUT) sh_timeout = cfg_data[TIMEOUT_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        predict_word(s_tuser, s_tdata[0], s_tdata[1], next_want);
        awaited_q.push_back(next_want);
      end
    end
    failures <= fail_count;
    outstanding <= awaited_q.size();
    compared <= compare_count;
    timeouts <= timeout_count;
    switch_stops <= switch_count;
  end

endmodule

@@ sim/shutter_motion_controller_tb.sv @@
`timescale 1ns / 1ps

// Top of the shutter controller regression. This module only makes stimulus
// and gives the verdict; the checker beside the block predicts and compares
// every result word.
module shutter_motion_controller_tb;
  import smc_pkg::*;

  // A register index that the block does not decode; writes to it must be
  // ignored.
  localparam logic [CFG_IDX_W-1:0] SPARE_REG = {CFG_IDX_W{1'b1}};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [0] switch_opened, [1] switch_closed
  logic [2:0]            s_tuser = '0;   // [2:0] kind
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;        // [2:0] shutter_status, [3] slewing,
                                         // [4] relay_open_on, [5] relay_close_on,
                                         // [6] accepted
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int failures;
  int outstanding;
  int compared;
  int timeouts;
  int switch_stops;

  // Longest gap before each event word and longest stall after each result
  // word. Setting either to zero gives a stretch at full rate on that side.
  int tx_max = 10;
  int rx_max = 10;
  int rx_stall = 0;
  int rx_gap;
  int events_sent = 0;
  int settings = 1;

  always #4 clk = ~clk;

  shutter_motion_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  shutter_motion_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .failures     (failures),
    .outstanding  (outstanding),
    .compared     (compared),
    .timeouts     (timeouts),
    .switch_stops (switch_stops)
  );

  // Result side: after every result word taken, ready drops for a random
  // stall drawn from 0 to rx_max. Ready stays high while the block
  // has nothing to send.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (m_tready) begin
      if (m_tvalid) begin
        rx_gap = $urandom_range(0, rx_max);
        if (rx_gap != 0) begin
          m_tready <= 1'b0;
          rx_stall <= rx_gap - 1;
        end
      end
    end else if (rx_stall == 0) begin
      m_tready <= 1'b1;
    end else begin
      rx_stall <= rx_stall - 1;
    end
  end

  // A limit switch level that is mostly low, so that motion usually runs for
  // a few ticks before the switch shows up.
  function automatic logic rare_level();
    return $urandom_range(0, 5) == 0;
  endfunction

  // New pace for both sides: usually random gaps, sometimes a stretch at full rate.
  task automatic pick_pace();
    tx_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
    rx_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
  endtask

  // Offers one event word after a random gap and returns at the edge where it
  // is taken. Valid stays high when the next word follows without a gap.
  task automatic send_event(input logic [2:0] k, input logic so, input logic sc);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= {6'b0, sc, so};
    do @(posedge clk); while (!s_tready);
    events_sent++;
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stops offering events and waits until every result word has come back
  // and the two pipeline stages have emptied.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Rewrites both registers while the block is idle. The upper data bits of
  // the mode register carry random junk that the block must ignore. With
  // spare set, writes to indexes that the block does not decode come first.
  task automatic configure(input logic use_sw, input logic [TIMEOUT_W-1:0] tmo,
                           input bit spare);
    settle();
    if (spare) begin
      write_reg(SPARE_REG, {CFG_DATA_W{1'b1}});
      write_reg(CFG_IDX_W'($urandom_range(REG_TIMEOUT + 1, 254)),
                CFG_DATA_W'($urandom_range(0, 4095)));
    end
    write_reg(REG_USE_SWITCHES, {11'($urandom_range(0, 2047)), use_sw});
    write_reg(REG_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Random traffic: mostly a command followed by a short run of ticks with
  // sparse switch levels, the rest single events of any kind with random
  // switch levels, including the unused kinds.
  task automatic shake_out(input int n);
    int sent;
    int ticks;
    logic to_open;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 7) begin
        pick_pace();
        to_open = 1'($urandom_range(0, 1));
        send_event(to_open ? KIND_OPEN : KIND_CLOSE, rare_level(), rare_level());
        ticks = $urandom_range(1, 8);
        repeat (ticks) send_event(KIND_TICK, rare_level(), rare_level());
        sent += 1 + ticks;
      end else begin
        send_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: timer mode with a 60 second timeout. A tick while idle
    // does nothing, and initialise in timer mode always reports an error.
    send_event(KIND_TICK, 1'b0, 1'b0);
    send_event(KIND_INIT, 1'b1, 1'b1);
    // Open, repeat the open, then try the opposite command while moving.
    send_event(KIND_OPEN, 1'b0, 1'b0);
    send_event(KIND_OPEN, 1'b0, 1'b0);
    send_event(KIND_CLOSE, 1'b0, 1'b0);
    // The open switch means nothing in timer mode.
    send_event(KIND_TICK, 1'b1, 1'b0);
    send_event(KIND_ABORT, 1'b0, 1'b0);
    send_event(KIND_CLOSE, 1'b0, 1'b0);
    send_event(KIND_OPEN, 1'b1, 1'b1);
    send_event(KIND_CLOSE, 1'b0, 1'b0);
    // Unused kinds are accepted and change nothing.
    for (int k = KIND_INIT + 1; k < 8; k++) send_event(3'(k), 1'b1, 1'b1);

    // Switch mode with the longest timeout.
    configure(1'b1, {TIMEOUT_W{1'b1}}, 1'b1);
    // Initialise: the closed switch wins over the open one, then the open one alone, then neither.
    send_event(KIND_INIT, 1'b1, 1'b1);
    send_event(KIND_INIT, 1'b1, 1'b0);
    send_event(KIND_INIT, 1'b0, 1'b0);
    // The wrong switch does not end motion; the matching one does.
    send_event(KIND_OPEN, 1'b0, 1'b0);
    send_event(KIND_TICK, 1'b0, 1'b1);
    send_event(KIND_TICK, 1'b1, 1'b0);
    send_event(KIND_CLOSE, 1'b0, 1'b0);
    send_event(KIND_TICK, 1'b1, 1'b1);
    // Initialise while moving changes only the status; relays and slewing
    // stay on, and later ticks find the shutter no longer moving.
    send_event(KIND_OPEN, 1'b0, 1'b1);
    send_event(KIND_INIT, 1'b0, 1'b1);
    send_event(KIND_TICK, 1'b1, 1'b0);
    send_event(KIND_ABORT, 1'b1, 1'b1);

    // Timer mode with no timeout at all: the first tick ends every motion.
    configure(1'b0, '0, 1'b0);
    shake_out(60);

    // Switch mode with no timeout: the first tick is an error, even when the
    // matching switch arrives on it.
    configure(1'b1, '0, 1'b0);
    shake_out(60);

    // Edge of the timeout in switch mode. With one second allowed, the tick
    // that brings the count to exactly the limit is still fine, and the next
    // one is a timeout that wins over the open switch seen with it.
    configure(1'b1, 12'd1, 1'b0);
    send_event(KIND_OPEN, 1'b0, 1'b0);
    for (int i = 0; i < MS_PER_SECOND; i++) begin
      if (i % 100 == 0) pick_pace();
      send_event(KIND_TICK, 1'b0, 1'($urandom_range(0, 1)));
    end
    send_event(KIND_TICK, 1'b1, 1'($urandom_range(0, 1)));

    // Timer mode with the longest timeout: motion only ends by abort or by initialise.
    configure(1'b0, {TIMEOUT_W{1'b1}}, 1'b0);
    shake_out(60);

    // Switch mode with short and then arbitrary timeouts.
    configure(1'b1, TIMEOUT_W'($urandom_range(1, 40)), 1'b1);
    shake_out(80);
    configure(1'b1, TIMEOUT_W'($urandom_range(0, 4095)), 1'b0);
    shake_out(60);

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d event words over %0d register settings, %0d result words compared.",
             events_sent, settings, compared);
    $display("Motion ended by timeout %0d times and by a limit switch %0d times.",
             timeouts, switch_stops);
    if (failures == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: the slowest correct run stays far below this.
  initial begin
    #2_000_000;
    $display("Timed out with %0d result words still expected.", outstanding);
    $display("Regression FAIL");
    $finish;
  end

endmodule
